### design/dpd_pkg.sv
package dpd_pkg;

  localparam logic [7:0] START_MARK = 8'h24;  // '$'
  localparam logic [7:0] CSUM_MARK  = 8'h23;  // '#'
  localparam logic [7:0] ACK_CHAR   = 8'h2B;  // '+'

  typedef enum logic [3:0] {
    PH_HUNT     = 4'b0001,
    PH_PAYLOAD  = 4'b0010,
    PH_DIGIT_HI = 4'b0100,
    PH_DIGIT_LO = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] sum;
    logic [3:0] hi_nibble;
    logic       hi_bad;
    logic       started;
  } dpd_state_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic       first;
    logic [7:0] sum;
  } dpd_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h = '0;
    case (c) inside
      [8'h30:8'h39]: begin
        h.ok  = 1'b1;
        h.val = c[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        h.ok  = 1'b1;
        h.val = 4'(c[2:0] + 3'd1) + 4'd8;
      end
      default: begin
        h = '0;
      end
    endcase
    return h;
  endfunction

endpackage

### design/debug_packet_deframer_unit.sv
// Path: an accepted byte is held in the input register; its result is registered when it advances.
// Throughput: one byte per cycle unless a result stalls; input register, one state update, result register.
// Bytes that give no result (hunting, markers, high digit) still pass the input register, never waiting.
// Reset: asynchronous, active low; both stages empty, framer hunting for the start marker,
// running sum and digit state cleared.
module debug_packet_deframer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       first_of_packet_o,
  output logic [7:0] computed_sum_o
);
  import dpd_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  dpd_state_t  state_q, state_d;
  dpd_result_t res;
  logic        out_valid_q, out_valid_d;
  dpd_result_t out_q;
  logic        out_free;
  logic        advance;

  dpd_step u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .state_o (state_d),
    .res_o   (res)
  );

  assign out_free   = ~out_valid_q | out_ready_i;
  // a byte without a result never waits for the output slot
  assign advance    = in_valid_q & (~res.valid | out_free);
  assign rx_ready_o = ~in_valid_q | advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_valid_i && rx_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      state_q           <= '{phase: PH_HUNT, sum: '0, hi_nibble: '0, hi_bad: 1'b0,
                             started: 1'b0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_q.kind;
  assign out_byte_o        = out_q.data;
  assign first_of_packet_o = out_q.first;
  assign computed_sum_o    = out_q.sum;

endmodule

### design/dpd_step.sv
module dpd_step (
  input  dpd_pkg::dpd_state_t  state_i,
  input  logic [7:0]           byte_i,
  output dpd_pkg::dpd_state_t  state_o,
  output dpd_pkg::dpd_result_t res_o
);
  import dpd_pkg::*;

  hex_digit_t hex;
  logic [7:0] sum_new;
  logic [7:0] received;

  assign hex      = hex_decode(byte_i);
  assign sum_new  = state_i.sum + byte_i;
  assign received = {state_i.hi_nibble, hex.val};

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    case (state_i.phase)
      PH_HUNT: begin
        if (byte_i == START_MARK) begin
          state_o.phase   = PH_PAYLOAD;
          state_o.sum     = '0;
          state_o.started = 1'b0;
        end
      end
      PH_PAYLOAD: begin
        if (byte_i == CSUM_MARK) begin
          state_o.phase = PH_DIGIT_HI;
        end else begin
          state_o.sum     = sum_new;
          state_o.started = 1'b1;
          res_o.valid     = 1'b1;
          res_o.kind      = KIND_PAYLOAD;
          res_o.data      = byte_i;
          res_o.first     = ~state_i.started;
          res_o.sum       = sum_new;
        end
      end
      PH_DIGIT_HI: begin
        // hold the high digit; no result until the low one
        state_o.hi_nibble = hex.val;
        state_o.hi_bad    = ~hex.ok;
        state_o.phase     = PH_DIGIT_LO;
      end
      PH_DIGIT_LO: begin
        res_o.valid   = 1'b1;
        res_o.kind    = (hex.ok && !state_i.hi_bad && received == state_i.sum) ?
                        KIND_ACCEPT : KIND_REJECT;
        res_o.data    = received;
        res_o.first   = 1'b0;
        res_o.sum     = state_i.sum;
        state_o.phase = PH_HUNT;
      end
      default: begin
        state_o.phase = PH_HUNT;
      end
    endcase
  end

endmodule

### design/dpd_checker.sv
module dpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] out_kind_o,
  input logic [7:0] out_byte_o,
  input logic       first_of_packet_o,
  input logic [7:0] computed_sum_o
);
  import dpd_pkg::*;

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_kind_o) &&
    $stable(out_byte_o) && $stable(first_of_packet_o) && $stable(computed_sum_o))
    else $error("result request dropped or changed while stalled");

  // the first payload byte starts the sum from zero
  a_first_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_of_packet_o |->
    out_kind_o == KIND_PAYLOAD && computed_sum_o == out_byte_o)
    else $error("first payload byte with a wrong sum");

  // an accept carries the matching checksum and is never marked first
  a_accept_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_ACCEPT |->
    out_byte_o == computed_sum_o && !first_of_packet_o)
    else $error("accept with mismatching checksum");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_kind_o == KIND_PAYLOAD || out_kind_o == KIND_ACCEPT ||
    out_kind_o == KIND_REJECT)
    else $error("unknown result kind");

endmodule

bind debug_packet_deframer_unit dpd_checker u_dpd_checker (.*);

### tb/sv/tb_debug_packet_deframer_unit.sv
`timescale 1ns / 1ps

module tb_debug_packet_deframer_unit;
  import dpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BYTES = 1400;
  localparam int unsigned QUIET_TAIL = 150;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic       first;
    logic [7:0] sum;
  } frame_result_t;

  typedef struct {
    bit         drain;
    logic [7:0] value;
  } rx_entry_t;

  logic       clk_i;
  logic       rst_ni;
  logic       rx_valid_i;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] out_kind_o;
  logic [7:0] out_byte_o;
  logic       first_of_packet_o;
  logic [7:0] computed_sum_o;

  debug_packet_deframer_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rx_valid_i        (rx_valid_i),
    .rx_ready_o        (rx_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_kind_o        (out_kind_o),
    .out_byte_o        (out_byte_o),
    .first_of_packet_o (first_of_packet_o),
    .computed_sum_o    (computed_sum_o)
  );

  // framer state as predicted
  phase_e     fr_phase;
  logic [7:0] fr_sum;
  logic [3:0] fr_hi_nibble;
  logic       fr_hi_bad;
  logic       fr_started;

  rx_entry_t     byte_queue[$];
  frame_result_t pending_results[$];

  int unsigned errors;
  int unsigned bytes_queued;
  int unsigned n_accept;
  int unsigned n_reject;
  int unsigned n_payload;
  int unsigned n_drains;

  bit          rx_fire;
  int unsigned src_gap;
  int unsigned sink_gap;
  logic        next_valid;
  logic [7:0]  next_byte;
  rx_entry_t   head_entry;

  // {ok, value}; value is 0 for a non-hex character
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, 4'(c - 8'h30)};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      return {1'b1, 4'(c - 8'h37)};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      return {1'b1, 4'(c - 8'h57)};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) begin
      return 8'h30 + 8'(nib);
    end
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  task automatic track_byte(input logic [7:0] c);
    logic [4:0]    dig;
    logic [7:0]    got;
    frame_result_t r;
    case (fr_phase)
      PH_HUNT: begin
        if (c == START_MARK) begin
          fr_phase   = PH_PAYLOAD;
          fr_sum     = 8'd0;
          fr_started = 1'b0;
        end
      end
      PH_PAYLOAD: begin
        if (c == CSUM_MARK) begin
          fr_phase = PH_DIGIT_HI;
        end else begin
          fr_sum  = fr_sum + c;
          r.kind  = KIND_PAYLOAD;
          r.data  = c;
          r.first = !fr_started;
          r.sum   = fr_sum;
          pending_results.push_back(r);
          fr_started = 1'b1;
        end
      end
      PH_DIGIT_HI: begin
        dig          = digit_value(c);
        fr_hi_nibble = dig[3:0];
        fr_hi_bad    = !dig[4];
        fr_phase     = PH_DIGIT_LO;
      end
      default: begin
        dig     = digit_value(c);
        got     = {fr_hi_nibble, dig[3:0]};
        r.kind  = (dig[4] && !fr_hi_bad && got == fr_sum) ? KIND_ACCEPT : KIND_REJECT;
        r.data  = got;
        r.first = 1'b0;
        r.sum   = fr_sum;
        pending_results.push_back(r);
        fr_phase = PH_HUNT;
      end
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] b);
    rx_entry_t e;
    e.drain = 1'b0;
    e.value = b;
    byte_queue.push_back(e);
    bytes_queued++;
  endtask

  task automatic queue_drain();
    rx_entry_t e;
    e.drain = 1'b1;
    e.value = 8'd0;
    byte_queue.push_back(e);
  endtask

  task automatic queue_random_packet();
    int unsigned len;
    int unsigned mode;
    logic [7:0]  b;
    logic [7:0]  sum;
    logic [7:0]  csum;
    // line noise ahead of the start marker
    repeat ($urandom_range(0, 2)) begin
      do b = 8'($urandom); while (b == START_MARK);
      queue_byte(b);
    end
    mode = $urandom_range(0, 19);
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
    sum  = 8'd0;
    queue_byte(START_MARK);
    repeat (len) begin
      b = 8'($urandom);
      // a stray checksum marker cuts the payload short; keep it only for broken packets
      if (b == CSUM_MARK && mode < 18) b = 8'h00;
      sum = sum + b;
      queue_byte(b);
    end
    queue_byte(CSUM_MARK);
    if (mode < 15) begin
      csum = sum;
    end else if (mode < 18) begin
      csum = sum ^ 8'($urandom_range(1, 255));
    end else begin
      csum = 8'd0;
    end
    if (mode < 18) begin
      queue_byte(hex_char(csum[7:4], 1'($urandom_range(0, 1))));
      queue_byte(hex_char(csum[3:0], 1'($urandom_range(0, 1))));
    end else begin
      queue_byte(8'($urandom));
      queue_byte(8'($urandom));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni      = 1'b0;
    rx_valid_i  = 1'b0;
    rx_byte_i   = 8'd0;
    out_ready_i = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // receiver side: random stall bursts, none in the tail
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      out_ready_i <= 1'b0;
      sink_gap--;
    end else if (byte_queue.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      sink_gap = $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // sender side: hold the request until taken, then advance through the queue
  always @(negedge clk_i) begin
    next_valid = rx_valid_i;
    next_byte  = rx_byte_i;
    if (rx_fire) next_valid = 1'b0;
    if (rst_ni && !next_valid) begin
      if (src_gap > 0) begin
        src_gap--;
      end else if (byte_queue.size() > 0) begin
        if (byte_queue[0].drain) begin
          if (pending_results.size() == 0) begin
            void'(byte_queue.pop_front());
            n_drains++;
          end
        end else if (byte_queue.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 5);
        end else begin
          head_entry = byte_queue.pop_front();
          next_valid = 1'b1;
          next_byte  = head_entry.value;
        end
      end
    end
    rx_valid_i <= next_valid;
    rx_byte_i  <= next_byte;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_fire      = 1'b0;
      fr_phase     = PH_HUNT;
      fr_sum       = 8'd0;
      fr_hi_nibble = 4'd0;
      fr_hi_bad    = 1'b0;
      fr_started   = 1'b0;
    end else begin
      rx_fire = rx_valid_i && rx_ready_o;
      if (rx_fire) track_byte(rx_byte_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: kind %0d byte %0h", out_kind_o, out_byte_o);
          errors++;
        end else begin
          frame_result_t r;
          r = pending_results.pop_front();
          if (out_kind_o !== r.kind) begin
            $error("out_kind: expected %0d, actual %0d", r.kind, out_kind_o);
            errors++;
          end
          if (out_byte_o !== r.data) begin
            $error("out_byte: expected %0h, actual %0h", r.data, out_byte_o);
            errors++;
          end
          if (first_of_packet_o !== r.first) begin
            $error("first_of_packet: expected %0b, actual %0b", r.first, first_of_packet_o);
            errors++;
          end
          if (computed_sum_o !== r.sum) begin
            $error("computed_sum: expected %0h, actual %0h", r.sum, computed_sum_o);
            errors++;
          end
          case (r.kind)
            KIND_ACCEPT: n_accept++;
            KIND_REJECT: n_reject++;
            default:     n_payload++;
          endcase
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned pkts;
    // noise before the start marker, including a stray checksum marker
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(CSUM_MARK);
    queue_byte(8'h78);
    // start marker and the byte extremes inside the payload
    queue_byte(START_MARK);
    queue_byte(START_MARK);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(CSUM_MARK);
    queue_byte(8'h32);
    queue_byte(8'h33);
    // empty payload, matching checksum
    queue_byte(START_MARK);
    queue_byte(CSUM_MARK);
    queue_byte(8'h30);
    queue_byte(8'h30);
    // non-hex low digit
    queue_byte(START_MARK);
    queue_byte(8'h41);
    queue_byte(CSUM_MARK);
    queue_byte(8'h34);
    queue_byte(8'h47);
    // markers taken as checksum digits
    queue_byte(START_MARK);
    queue_byte(CSUM_MARK);
    queue_byte(START_MARK);
    queue_byte(CSUM_MARK);
    queue_drain();

    bytes_queued = 0;
    pkts = 0;
    while (bytes_queued < RANDOM_BYTES) begin
      if (pkts % 60 == 30) queue_drain();
      queue_random_packet();
      pkts++;
    end

    @(posedge rst_ni);
    do @(negedge clk_i);
    while (byte_queue.size() != 0 || rx_valid_i || pending_results.size() != 0);
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end

    $display("Covered %0d random packets plus directed framing cases, %0d drain pauses.",
             pkts, n_drains);
    $display("Results seen: %0d payload bytes, %0d accepted, %0d rejected.",
             n_payload, n_accept, n_reject);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
